// ===== rtl/rv32ex_pkg.sv =====
// ----------------------------------------------------------------------------
// RV32I execute unit package
// Shared constants, instruction kind and operation codes, and item types.
// ----------------------------------------------------------------------------
`default_nettype none

package rv32ex_pkg;

  localparam int unsigned DataBytes = 65536;
  localparam int unsigned DataAw    = $clog2(DataBytes);
  localparam int unsigned RowDepth  = DataBytes / 4;
  localparam int unsigned RowAw     = DataAw - 2;
  localparam int unsigned NumRegs   = 32;

  typedef enum logic [3:0] {
    KindReg    = 4'd0,
    KindImm    = 4'd1,
    KindShImm  = 4'd2,
    KindLoad   = 4'd3,
    KindStore  = 4'd4,
    KindBranch = 4'd5,
    KindUpper  = 4'd6,
    KindJal    = 4'd7,
    KindJalr   = 4'd8,
    KindSystem = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    TrapNone    = 2'd0,
    TrapIllegal = 2'd1,
    TrapEcall   = 2'd2,
    TrapBreak   = 2'd3
  } trap_e;

  // Register operations.
  localparam logic [3:0] OpAdd  = 4'd0;
  localparam logic [3:0] OpSub  = 4'd1;
  localparam logic [3:0] OpXor  = 4'd2;
  localparam logic [3:0] OpOr   = 4'd3;
  localparam logic [3:0] OpAnd  = 4'd4;
  localparam logic [3:0] OpSll  = 4'd5;
  localparam logic [3:0] OpSrl  = 4'd6;
  localparam logic [3:0] OpSra  = 4'd7;
  localparam logic [3:0] OpSlt  = 4'd8;
  localparam logic [3:0] OpSltu = 4'd9;

  // Immediate operations.
  localparam logic [3:0] OpAddi  = 4'd0;
  localparam logic [3:0] OpXori  = 4'd1;
  localparam logic [3:0] OpOri   = 4'd2;
  localparam logic [3:0] OpAndi  = 4'd3;
  localparam logic [3:0] OpSlti  = 4'd4;
  localparam logic [3:0] OpSltiu = 4'd5;

  // Shift-immediate operations.
  localparam logic [3:0] OpSlli = 4'd0;
  localparam logic [3:0] OpSrli = 4'd1;
  localparam logic [3:0] OpSrai = 4'd2;

  // Loads.
  localparam logic [3:0] OpLb  = 4'd0;
  localparam logic [3:0] OpLh  = 4'd1;
  localparam logic [3:0] OpLw  = 4'd2;
  localparam logic [3:0] OpLbu = 4'd3;
  localparam logic [3:0] OpLhu = 4'd4;

  // Stores.
  localparam logic [3:0] OpSb = 4'd0;
  localparam logic [3:0] OpSh = 4'd1;
  localparam logic [3:0] OpSw = 4'd2;

  // Branches.
  localparam logic [3:0] OpBeq  = 4'd0;
  localparam logic [3:0] OpBne  = 4'd1;
  localparam logic [3:0] OpBlt  = 4'd2;
  localparam logic [3:0] OpBge  = 4'd3;
  localparam logic [3:0] OpBltu = 4'd4;
  localparam logic [3:0] OpBgeu = 4'd5;

  // Upper immediates.
  localparam logic [3:0] OpLui   = 4'd0;
  localparam logic [3:0] OpAuipc = 4'd1;

  // System.
  localparam logic [3:0] OpEcall  = 4'd0;
  localparam logic [3:0] OpEbreak = 4'd1;

  typedef struct packed {
    logic [3:0]         kind;
    logic [3:0]         op;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [4:0]         shift_amount;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  trap_code;
    logic        reg_written;
    logic [4:0]  written_index;
    logic [31:0] written_value;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/rv32ex_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read that holds its
// data while no read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ex_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rv32i_execute_unit.sv =====
// ----------------------------------------------------------------------------
// RV32I execute unit
// Executes one decoded RV32I instruction per item against the program
// counter, a 32-entry register file and a byte-addressed data memory.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-------------------------
//   in      | to unit   | in_valid_i / in_stall_o | in_item_i  (in_item_t)
//   out     | from unit | out_valid_o / out_stall_i | out_item_o (out_item_t)
//
// One item is taken per cycle unless in_stall_o is high; each result is held in
// the writeback registers. The register file is read when an item is taken and
// the instruction runs in the execute stage, where data memory is read or written.
// Results of the two preceding instructions are forwarded, load data included.
// Reset clears the program counter and the register file valid bits at once.
// A stalled output holds its result and stops the input only when both stages
// are occupied.
`default_nettype none

module rv32i_execute_unit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire rv32ex_pkg::in_item_t  in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output rv32ex_pkg::out_item_t      out_item_o
);

  import rv32ex_pkg::*;

  logic        in_acc;
  logic        out_acc;
  logic        ex_adv;

  logic        ex_valid_q;
  in_item_t    ex_item_q;
  logic        ex_v1_q;
  logic        ex_v2_q;
  logic [31:0] pc_q;

  logic [NumRegs-1:0] rf_valid_q;
  logic [31:0] rf_a_rdata;
  logic [31:0] rf_b_rdata;

  logic        wb_valid_q;
  logic [31:0] wb_next_q;
  trap_e       wb_trap_q;
  logic        wb_wr_q;
  logic [4:0]  wb_idx_q;
  logic [31:0] wb_val_q;
  logic        wb_load_q;
  logic [3:0]  wb_lop_q;
  logic [1:0]  wb_off_q;
  logic [31:0] wb_value;

  logic        ret_valid_q;
  logic [4:0]  ret_idx_q;
  logic [31:0] ret_val_q;

  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] imm;
  logic [31:0] addr;

  logic [31:0] ex_next;
  trap_e       ex_trap;
  logic        ex_wr;
  logic [31:0] ex_val;
  logic        ex_load;
  logic        ex_store;
  logic [2:0]  ex_nbytes;

  logic [RowAw-1:0] row_base;
  logic [1:0]       off;
  logic [7:0]       lane_rdata [4];
  logic [31:0]      ld_word;
  logic [31:0]      ld_val;

  assign in_stall_o  = ex_valid_q && wb_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = wb_valid_q;
  assign out_acc     = wb_valid_q && !out_stall_i;
  assign ex_adv      = ex_valid_q && (!wb_valid_q || !out_stall_i);

  // Register file: two copies, one per read port, written together.
  rv32ex_ram #(.Width(32), .Depth(NumRegs)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (out_acc && wb_wr_q),
    .waddr_i (wb_idx_q),
    .wdata_i (wb_value),
    .re_i    (in_acc),
    .raddr_i (in_item_i.src1_reg),
    .rdata_o (rf_a_rdata)
  );

  rv32ex_ram #(.Width(32), .Depth(NumRegs)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (out_acc && wb_wr_q),
    .waddr_i (wb_idx_q),
    .wdata_i (wb_value),
    .re_i    (in_acc),
    .raddr_i (in_item_i.src2_reg),
    .rdata_o (rf_b_rdata)
  );

  function automatic logic [31:0] fwd_operand(
    input logic [4:0]  idx,
    input logic        ram_valid,
    input logic [31:0] ram_data,
    input logic        wb_hit_en,
    input logic [4:0]  wb_idx,
    input logic [31:0] wb_data,
    input logic        ret_en,
    input logic [4:0]  ret_idx,
    input logic [31:0] ret_data
  );
    logic [31:0] r;
    if (idx == 5'd0) begin
      r = 32'd0;
    end else if (wb_hit_en && wb_idx == idx) begin
      r = wb_data;
    end else if (ret_en && ret_idx == idx) begin
      r = ret_data;
    end else if (ram_valid) begin
      r = ram_data;
    end else begin
      r = 32'd0;
    end
    return r;
  endfunction

  assign op_a = fwd_operand(ex_item_q.src1_reg, ex_v1_q, rf_a_rdata,
                            wb_valid_q && wb_wr_q, wb_idx_q, wb_value,
                            ret_valid_q, ret_idx_q, ret_val_q);
  assign op_b = fwd_operand(ex_item_q.src2_reg, ex_v2_q, rf_b_rdata,
                            wb_valid_q && wb_wr_q, wb_idx_q, wb_value,
                            ret_valid_q, ret_idx_q, ret_val_q);
  assign imm  = ex_item_q.immediate;
  assign addr = op_a + imm;

  always_comb begin
    logic taken;
    logic wr;
    taken     = 1'b0;
    wr        = 1'b0;
    ex_next   = pc_q + 32'd4;
    ex_trap   = TrapNone;
    ex_val    = 32'd0;
    ex_load   = 1'b0;
    ex_store  = 1'b0;
    ex_nbytes = 3'd0;
    case (kind_e'(ex_item_q.kind))
      KindReg: begin
        wr = 1'b1;
        case (ex_item_q.op)
          OpAdd:   ex_val = op_a + op_b;
          OpSub:   ex_val = op_a - op_b;
          OpXor:   ex_val = op_a ^ op_b;
          OpOr:    ex_val = op_a | op_b;
          OpAnd:   ex_val = op_a & op_b;
          OpSll:   ex_val = op_a << op_b[4:0];
          OpSrl:   ex_val = op_a >> op_b[4:0];
          OpSra:   ex_val = 32'($signed(op_a) >>> op_b[4:0]);
          OpSlt:   ex_val = {31'd0, $signed(op_a) < $signed(op_b)};
          OpSltu:  ex_val = {31'd0, op_a < op_b};
          default: ex_trap = TrapIllegal;
        endcase
      end
      KindImm: begin
        wr = 1'b1;
        case (ex_item_q.op)
          OpAddi:  ex_val = op_a + imm;
          OpXori:  ex_val = op_a ^ imm;
          OpOri:   ex_val = op_a | imm;
          OpAndi:  ex_val = op_a & imm;
          OpSlti:  ex_val = {31'd0, $signed(op_a) < $signed(imm)};
          OpSltiu: ex_val = {31'd0, op_a < imm};
          default: ex_trap = TrapIllegal;
        endcase
      end
      KindShImm: begin
        wr = 1'b1;
        case (ex_item_q.op)
          OpSlli:  ex_val = op_a << ex_item_q.shift_amount;
          OpSrli:  ex_val = op_a >> ex_item_q.shift_amount;
          OpSrai:  ex_val = 32'($signed(op_a) >>> ex_item_q.shift_amount);
          default: ex_trap = TrapIllegal;
        endcase
      end
      KindLoad: begin
        wr = 1'b1;
        case (ex_item_q.op)
          OpLb, OpLh, OpLw, OpLbu, OpLhu: ex_load = 1'b1;
          default: ex_trap = TrapIllegal;
        endcase
      end
      KindStore: begin
        case (ex_item_q.op)
          OpSb:    ex_nbytes = 3'd1;
          OpSh:    ex_nbytes = 3'd2;
          OpSw:    ex_nbytes = 3'd4;
          default: ex_trap = TrapIllegal;
        endcase
        ex_store = (ex_trap == TrapNone);
      end
      KindBranch: begin
        case (ex_item_q.op)
          OpBeq:   taken = (op_a == op_b);
          OpBne:   taken = (op_a != op_b);
          OpBlt:   taken = ($signed(op_a) < $signed(op_b));
          OpBge:   taken = !($signed(op_a) < $signed(op_b));
          OpBltu:  taken = (op_a < op_b);
          OpBgeu:  taken = (op_a >= op_b);
          default: ex_trap = TrapIllegal;
        endcase
        if (taken) begin
          ex_next = pc_q + imm;
        end
      end
      KindUpper: begin
        wr = 1'b1;
        case (ex_item_q.op)
          OpLui:   ex_val = imm;
          OpAuipc: ex_val = pc_q + imm;
          default: ex_trap = TrapIllegal;
        endcase
      end
      KindJal: begin
        wr      = 1'b1;
        ex_val  = pc_q + 32'd4;
        ex_next = pc_q + imm;
      end
      KindJalr: begin
        wr      = 1'b1;
        ex_val  = pc_q + 32'd4;
        ex_next = addr & ~32'd1;
      end
      KindSystem: begin
        case (ex_item_q.op)
          OpEcall:  ex_trap = TrapEcall;
          OpEbreak: ex_trap = TrapBreak;
          default:  ex_trap = TrapIllegal;
        endcase
      end
      default: ex_trap = TrapIllegal;
    endcase
    if (ex_trap != TrapNone) begin
      ex_next = pc_q;
      wr      = 1'b0;
      ex_load = 1'b0;
    end
    ex_wr = wr && (ex_item_q.dest_reg != 5'd0);
    if (!ex_wr) begin
      ex_val  = 32'd0;
      ex_load = 1'b0;
    end
  end

  // Data memory as four byte lanes; lane L holds the bytes whose address
  // is L modulo four, so any access of up to four bytes touches each lane at most once.
  assign row_base = addr[DataAw-1:2];
  assign off      = addr[1:0];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic [1:0]       k;
    logic [RowAw-1:0] row;
    logic             lane_we;
    assign k       = 2'(g) - off;
    assign row     = (2'(g) < off) ? row_base + RowAw'(1) : row_base;
    assign lane_we = ex_adv && ex_store && ({1'b0, k} < ex_nbytes);

    rv32ex_ram #(.Width(8), .Depth(RowDepth)) u_dmem (
      .clk_i   (clk_i),
      .we_i    (lane_we),
      .waddr_i (row),
      .wdata_i (op_b[8*k +: 8]),
      .re_i    (ex_adv && ex_load),
      .raddr_i (row),
      .rdata_o (lane_rdata[g])
    );
  end

  assign ld_word = {lane_rdata[wb_off_q + 2'd3], lane_rdata[wb_off_q + 2'd2],
                    lane_rdata[wb_off_q + 2'd1], lane_rdata[wb_off_q]};

  always_comb begin
    case (wb_lop_q)
      OpLb:    ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
      OpLh:    ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
      OpLw:    ld_val = ld_word;
      OpLbu:   ld_val = {24'd0, ld_word[7:0]};
      OpLhu:   ld_val = {16'd0, ld_word[15:0]};
      default: ld_val = 32'd0;
    endcase
  end

  assign wb_value = wb_load_q ? ld_val : wb_val_q;

  assign out_item_o.next_pc       = wb_next_q;
  assign out_item_o.trap_code     = wb_trap_q;
  assign out_item_o.reg_written   = wb_wr_q;
  assign out_item_o.written_index = wb_idx_q;
  assign out_item_o.written_value = wb_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      wb_valid_q  <= 1'b0;
      ret_valid_q <= 1'b0;
      pc_q        <= 32'd0;
      rf_valid_q  <= '0;
    end else begin
      if (in_acc) begin
        ex_valid_q <= 1'b1;
      end else if (ex_adv) begin
        ex_valid_q <= 1'b0;
      end
      if (ex_adv) begin
        wb_valid_q <= 1'b1;
        pc_q       <= ex_next;
      end else if (out_acc) begin
        wb_valid_q <= 1'b0;
      end
      if (out_acc && wb_wr_q) begin
        ret_valid_q          <= 1'b1;
        rf_valid_q[wb_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ex_item_q <= in_item_i;
      ex_v1_q   <= rf_valid_q[in_item_i.src1_reg];
      ex_v2_q   <= rf_valid_q[in_item_i.src2_reg];
    end
    if (ex_adv) begin
      wb_next_q <= ex_next;
      wb_trap_q <= ex_trap;
      wb_wr_q   <= ex_wr;
      wb_idx_q  <= ex_wr ? ex_item_q.dest_reg : 5'd0;
      wb_val_q  <= ex_val;
      wb_load_q <= ex_load;
      wb_lop_q  <= ex_item_q.op;
      wb_off_q  <= off;
    end
    if (out_acc && wb_wr_q) begin
      ret_idx_q <= wb_idx_q;
      ret_val_q <= wb_value;
    end
  end

`ifndef ASSERT_OFF
  a_trap_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.trap_code != TrapNone) |-> !out_item_o.reg_written)
    else $error("trapping item reports a register write");

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.reg_written |-> (out_item_o.written_index != 5'd0))
    else $error("write to x0 reported");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.reg_written
      |-> (out_item_o.written_index == 5'd0) && (out_item_o.written_value == 32'd0))
    else $error("item without write carries index or value");

  a_pc_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ex_adv |=> $stable(pc_q))
    else $error("program counter changed without an executed item");

  a_trap_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_adv && (ex_trap != TrapNone) |=> (pc_q == $past(pc_q)))
    else $error("program counter moved on a trap");
`endif

endmodule

`default_nettype wire
